// ===== src/mu8d_pkg.sv =====
package mu8d_pkg;

  localparam logic [30:0] MaxCodePoint = 31'h10FFFF;
  localparam logic [30:0] NoncharLo    = 31'h00FDD0;
  localparam logic [30:0] NoncharHi    = 31'h00FDEF;
  localparam logic [15:0] NoncharTail  = 16'hFFFE;
  localparam logic [30:0] SurrogateLo  = 31'h00D800;
  localparam logic [30:0] SurrogateHi  = 31'h00DFFF;
  localparam logic [7:0]  ImpossibleLo = 8'hFE;

  typedef struct packed {
    logic [20:0] code_point;
    logic        valid_res;
    logic        terminator;
    logic [2:0]  bytes_consumed;
  } mu8d_res_t;

  // One queue entry holds every result that a single input beat causes.
  typedef struct packed {
    logic      two;
    mu8d_res_t first;
    mu8d_res_t second;
  } mu8d_entry_t;

  function automatic logic [30:0] min_value(logic [2:0] len);
    logic [30:0] v;
    case (len)
      3'd2:    v = 31'h80;
      3'd3:    v = 31'h800;
      3'd4:    v = 31'h10000;
      3'd5:    v = 31'h200000;
      3'd6:    v = 31'h4000000;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic allowed_value(logic [30:0] cp);
    logic ok;
    ok = 1'b1;
    if (cp > MaxCodePoint) ok = 1'b0;
    if (cp >= NoncharLo && cp <= NoncharHi) ok = 1'b0;
    if ((cp[15:0] & NoncharTail) == NoncharTail) ok = 1'b0;
    if (cp >= SurrogateLo && cp <= SurrogateHi) ok = 1'b0;
    return ok;
  endfunction

endpackage

// ===== src/mu8d_front.sv =====
module mu8d_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 final_byte_i,
  output logic                 wr_o,
  output mu8d_pkg::mu8d_entry_t entry_o
);
  import mu8d_pkg::*;

  typedef struct packed {
    logic      emit;
    mu8d_res_t res;
    logic [2:0] len;
    logic [4:0] acc;
  } start_t;

  logic [30:0] acc_q, acc_d;
  logic [2:0]  seq_len_q, seq_len_d;
  logic [2:0]  seen_q, seen_d;

  function automatic start_t start_fn(logic [7:0] b, logic fin);
    start_t s;
    s = '0;
    if (b == 8'h00) begin
      s.emit = 1'b1;
      s.res.terminator = 1'b1;
    end else if (!b[7]) begin
      s.emit = 1'b1;
      s.res.code_point = 21'(b);
      s.res.valid_res = 1'b1;
      s.res.bytes_consumed = 3'd1;
    end else if (b >= ImpossibleLo || !b[6]) begin
      s.emit = 1'b1;
      s.res.bytes_consumed = 3'd1;
    end else begin
      case (b) inside
        8'b110?????: begin
          s.len = 3'd2;
          s.acc = b[4:0];
        end
        8'b1110????: begin
          s.len = 3'd3;
          s.acc = {1'b0, b[3:0]};
        end
        8'b11110???: begin
          s.len = 3'd4;
          s.acc = {2'b0, b[2:0]};
        end
        8'b111110??: begin
          s.len = 3'd5;
          s.acc = {3'b0, b[1:0]};
        end
        default: begin
          s.len = 3'd6;
          s.acc = {4'b0, b[0]};
        end
      endcase
      // a lead byte with nothing after it is a broken sequence
      if (fin) begin
        s.emit = 1'b1;
        s.res.bytes_consumed = 3'd1;
      end
    end
    return s;
  endfunction

  start_t      st;
  logic [30:0] acc_next;
  logic [2:0]  seen_next;
  logic        cp_ok;

  always_comb begin
    st        = start_fn(data_byte_i, final_byte_i);
    acc_next  = {acc_q[24:0], data_byte_i[5:0]};
    seen_next = 3'(seen_q + 3'd1);
    cp_ok     = allowed_value(acc_next);
    if (acc_next < min_value(seq_len_q) && !(acc_next == '0 && seq_len_q == 3'd2)) begin
      cp_ok = 1'b0;
    end

    acc_d     = acc_q;
    seq_len_d = seq_len_q;
    seen_d    = seen_q;
    wr_o      = 1'b0;
    entry_o   = '0;

    if (accept_i) begin
      if (seq_len_q == 3'd0) begin
        if (st.emit) begin
          wr_o          = 1'b1;
          entry_o.first = st.res;
        end else begin
          acc_d     = 31'(st.acc);
          seq_len_d = st.len;
          seen_d    = 3'd1;
        end
      end else if (data_byte_i[7:6] == 2'b10) begin
        if (seen_next >= seq_len_q) begin
          wr_o                         = 1'b1;
          entry_o.first.code_point     = cp_ok ? acc_next[20:0] : '0;
          entry_o.first.valid_res      = cp_ok;
          entry_o.first.bytes_consumed = seq_len_q;
          acc_d     = '0;
          seq_len_d = '0;
          seen_d    = '0;
        end else if (final_byte_i) begin
          wr_o                         = 1'b1;
          entry_o.first.bytes_consumed = seen_next;
          acc_d     = '0;
          seq_len_d = '0;
          seen_d    = '0;
        end else begin
          acc_d  = acc_next;
          seen_d = seen_next;
        end
      end else begin
        // report the broken sequence, then take this byte as a fresh start
        wr_o                         = 1'b1;
        entry_o.first.bytes_consumed = seen_q;
        acc_d     = '0;
        seq_len_d = '0;
        seen_d    = '0;
        if (st.emit) begin
          entry_o.two    = 1'b1;
          entry_o.second = st.res;
        end else begin
          acc_d     = 31'(st.acc);
          seq_len_d = st.len;
          seen_d    = 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      seq_len_q <= '0;
      seen_q    <= '0;
    end else begin
      acc_q     <= acc_d;
      seq_len_q <= seq_len_d;
      seen_q    <= seen_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_len_q == 3'd0) |-> (seen_q == 3'd0 && acc_q == '0))
    else $error("closed sequence holds stale state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_len_q != 3'd0) |-> (seq_len_q >= 3'd2 && seq_len_q <= 3'd6 &&
                             seen_q >= 3'd1 && seen_q < seq_len_q))
    else $error("open sequence counts out of range");

endmodule

// ===== src/mu8d_fifo.sv =====
module mu8d_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_i,
  input  mu8d_pkg::mu8d_entry_t wr_data_i,
  input  logic                  rd_i,
  output mu8d_pkg::mu8d_entry_t rd_data_o,
  output logic                  full_o,
  output logic                  empty_o
);
  import mu8d_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  mu8d_entry_t     mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : PtrW'(p + 1'b1);
  endfunction

  assign full_o    = (count_q == CntW'(Depth));
  assign empty_o   = (count_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wr_ptr_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_i) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (rd_i) rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (wr_i && !rd_i) count_q <= CntW'(count_q + 1'b1);
      else if (rd_i && !wr_i) count_q <= CntW'(count_q - 1'b1);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) wr_i |-> !full_o)
    else $error("write into full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni) rd_i |-> !empty_o)
    else $error("read from empty queue");

endmodule

// ===== src/mu8d_back.sv =====
module mu8d_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fifo_empty_i,
  input  mu8d_pkg::mu8d_entry_t head_i,
  output logic                  rd_o,
  input  logic                  pop,
  output logic                  empty,
  output logic [20:0]           code_point_o,
  output logic                  valid_res_o,
  output logic                  terminator_o,
  output logic [2:0]            bytes_consumed_o,
  output logic                  last_of_run_o
);
  import mu8d_pkg::*;

  logic      out_valid_q, out_valid_d;
  logic      sel_q, sel_d;
  logic      last_q, last_d;
  mu8d_res_t res_q, res_d;
  logic      load;

  always_comb begin
    load        = !out_valid_q || pop;
    out_valid_d = out_valid_q;
    sel_d       = sel_q;
    last_d      = last_q;
    res_d       = res_q;
    rd_o        = 1'b0;
    if (load) begin
      out_valid_d = !fifo_empty_i;
      if (!fifo_empty_i) begin
        if (head_i.two && !sel_q) begin
          // hold the entry; its second result follows
          res_d  = head_i.first;
          last_d = 1'b0;
          sel_d  = 1'b1;
        end else begin
          res_d  = sel_q ? head_i.second : head_i.first;
          last_d = 1'b1;
          sel_d  = 1'b0;
          rd_o   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sel_q       <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      sel_q       <= sel_d;
      last_q      <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign empty            = !out_valid_q;
  assign code_point_o     = res_q.code_point;
  assign valid_res_o      = res_q.valid_res;
  assign terminator_o     = res_q.terminator;
  assign bytes_consumed_o = res_q.bytes_consumed;
  assign last_of_run_o    = last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_q |-> (!fifo_empty_i && out_valid_q && !last_q))
    else $error("second result pending without its entry");

endmodule

// ===== src/modified_utf8_decoder_core.sv =====
// Streaming decoder for modified UTF-8 (U+0000 may also arrive as C0 80).
// Input channel: one byte per beat on data_byte_i with final_byte_i marking
// the last byte of the stream; a beat is taken when push is high and full is
// low. Result channel: while empty is low the oldest result sits on the
// result ports and is taken when pop is high.
// Each byte causes zero, one or two results; last_of_run_o flags the last
// result caused by a byte. A byte that breaks an open sequence yields an
// error result and is then decoded again as a sequence start.
// Throughput: one byte per cycle while full is low, one result per cycle
// while pop is high and results wait. A byte that yields two results holds
// its queue entry until both have passed the output register; the queue of
// QueueDepth entries between the decode front and the output stage absorbs
// that, and full rises only when the queue has no free entry.
// A taken byte is written into the queue, and its first result moves from
// the queue into the output register when the output is free.
// Reset clears the open sequence, the queue and the output valid flag.
// When the receiver stalls, the output register holds, the queue fills and
// full then holds off the sender; nothing is dropped.
module modified_utf8_decoder_core #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        final_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [20:0] code_point_o,
  output logic        valid_res_o,
  output logic        terminator_o,
  output logic [2:0]  bytes_consumed_o,
  output logic        last_of_run_o
);
  import mu8d_pkg::*;

  logic        accept;
  logic        wr;
  logic        rd;
  logic        fifo_empty;
  mu8d_entry_t wr_entry;
  mu8d_entry_t head;

  assign accept = push && !full;

  mu8d_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .data_byte_i  (data_byte_i),
    .final_byte_i (final_byte_i),
    .wr_o         (wr),
    .entry_o      (wr_entry)
  );

  mu8d_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .wr_data_i (wr_entry),
    .rd_i      (rd),
    .rd_data_o (head),
    .full_o    (full),
    .empty_o   (fifo_empty)
  );

  mu8d_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .fifo_empty_i     (fifo_empty),
    .head_i           (head),
    .rd_o             (rd),
    .pop              (pop),
    .empty            (empty),
    .code_point_o     (code_point_o),
    .valid_res_o      (valid_res_o),
    .terminator_o     (terminator_o),
    .bytes_consumed_o (bytes_consumed_o),
    .last_of_run_o    (last_of_run_o)
  );

endmodule

// ===== tb/tb_modified_utf8_decoder_core.sv =====
`timescale 1ns / 100ps

module tb_modified_utf8_decoder_core;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } byte_beat_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic        valid_res;
    logic        terminator;
    logic [2:0]  bytes_consumed;
    logic        last_of_run;
  } decoded_t;

  localparam int unsigned RandomBytes = 1750;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [7:0]  data_byte;
  logic        final_byte;
  logic        empty;
  logic        pop;
  logic [20:0] code_point;
  logic        valid_res;
  logic        terminator;
  logic [2:0]  bytes_consumed;
  logic        last_of_run;

  byte_beat_t  byte_q[$];
  decoded_t    expected_results[$];

  // decoder shadow state
  logic [30:0] cp_acc;
  logic [2:0]  seq_len;
  logic [2:0]  seq_seen;
  decoded_t    run_buf[2];
  int          run_len;

  int mismatches;
  int results_seen;
  int valid_seen;
  int term_seen;
  int two_result_bytes;
  int bytes_sent;

  int burst_left;
  int gap_left;
  int pop_go;
  int pop_hold;
  logic pop_sparse;

  modified_utf8_decoder_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .data_byte_i      (data_byte),
    .final_byte_i     (final_byte),
    .empty            (empty),
    .pop              (pop),
    .code_point_o     (code_point),
    .valid_res_o      (valid_res),
    .terminator_o     (terminator),
    .bytes_consumed_o (bytes_consumed),
    .last_of_run_o    (last_of_run)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task add_byte(input logic [7:0] b, input logic fin);
    byte_beat_t beat;
    beat.data = b;
    beat.fin  = fin;
    byte_q.push_back(beat);
  endtask

  task add_result(input logic [30:0] cp, input logic ok, input logic term,
                  input logic [2:0] n);
    decoded_t r;
    r.code_point     = ok ? cp[20:0] : 21'd0;
    r.valid_res      = ok;
    r.terminator     = term;
    r.bytes_consumed = n;
    r.last_of_run    = 1'b0;
    run_buf[run_len] = r;
    run_len++;
  endtask

  task close_sequence();
    cp_acc   = '0;
    seq_len  = '0;
    seq_seen = '0;
  endtask

  task start_sequence(input logic [7:0] b, input logic fin);
    logic [2:0] lead_len;
    int i;
    lead_len = '0;
    if (b == 8'h00) begin
      add_result('0, 1'b0, 1'b1, 3'd0);
    end else if (!b[7]) begin
      add_result({23'd0, b}, 1'b1, 1'b0, 3'd1);
    end else if (b >= 8'hFE || !b[6]) begin
      add_result('0, 1'b0, 1'b0, 3'd1);
    end else begin
      for (i = 7; i >= 0 && b[i]; i--) lead_len++;
      if (fin) begin
        add_result('0, 1'b0, 1'b0, 3'd1);
      end else begin
        cp_acc   = {23'd0, b & ((8'h80 >> lead_len) - 8'd1)};
        seq_len  = lead_len;
        seq_seen = 3'd1;
      end
    end
  endtask

  function automatic logic cp_allowed(input logic [30:0] cp);
    if (cp > 31'h10FFFF) return 1'b0;
    if (cp >= 31'hFDD0 && cp <= 31'hFDEF) return 1'b0;
    if (cp[15:1] == 15'h7FFF) return 1'b0;
    if (cp >= 31'hD800 && cp <= 31'hDFFF) return 1'b0;
    return 1'b1;
  endfunction

  // Work out every result one input byte causes and queue them.
  task decode_byte(input logic [7:0] b, input logic fin);
    logic        ok;
    logic [30:0] shortest;
    int i;
    run_len = 0;
    if (seq_len == 3'd0) begin
      start_sequence(b, fin);
    end else if (b[7:6] == 2'b10) begin
      cp_acc = {cp_acc[24:0], b[5:0]};
      seq_seen++;
      if (seq_seen >= seq_len) begin
        case (seq_len)
          3'd2:    shortest = 31'h80;
          3'd3:    shortest = 31'h800;
          3'd4:    shortest = 31'h10000;
          3'd5:    shortest = 31'h200000;
          default: shortest = 31'h4000000;
        endcase
        ok = cp_allowed(cp_acc);
        // C0 80 is the one overlong form that stands
        if (cp_acc < shortest && !(cp_acc == '0 && seq_len == 3'd2)) ok = 1'b0;
        add_result(cp_acc, ok, 1'b0, seq_len);
        close_sequence();
      end else if (fin) begin
        add_result('0, 1'b0, 1'b0, seq_seen);
        close_sequence();
      end
    end else begin
      // broken sequence: report it, then decode this byte from scratch
      add_result('0, 1'b0, 1'b0, seq_seen);
      close_sequence();
      start_sequence(b, fin);
    end
    if (run_len > 0) run_buf[run_len-1].last_of_run = 1'b1;
    if (run_len == 2) two_result_bytes++;
    for (i = 0; i < run_len; i++) expected_results.push_back(run_buf[i]);
  endtask

  task check_result();
    decoded_t want;
    results_seen++;
    if (valid_res) valid_seen++;
    if (terminator) term_seen++;
    if (expected_results.size() == 0) begin
      $error("unexpected result: code_point %h valid_res %b bytes_consumed %0d",
             code_point, valid_res, bytes_consumed);
      mismatches++;
    end else begin
      want = expected_results.pop_front();
      if (code_point !== want.code_point) begin
        $error("code_point: expected %h, got %h", want.code_point, code_point);
        mismatches++;
      end
      if (valid_res !== want.valid_res) begin
        $error("valid_res: expected %b, got %b", want.valid_res, valid_res);
        mismatches++;
      end
      if (terminator !== want.terminator) begin
        $error("terminator: expected %b, got %b", want.terminator, terminator);
        mismatches++;
      end
      if (bytes_consumed !== want.bytes_consumed) begin
        $error("bytes_consumed: expected %0d, got %0d", want.bytes_consumed,
               bytes_consumed);
        mismatches++;
      end
      if (last_of_run !== want.last_of_run) begin
        $error("last_of_run: expected %b, got %b", want.last_of_run, last_of_run);
        mismatches++;
      end
    end
  endtask

  function automatic logic [30:0] pick_code_point();
    logic [30:0] v;
    case ($urandom_range(0, 9))
      0: v = 31'($urandom_range(1, 'h7F));
      1: v = 31'($urandom_range('h80, 'h7FF));
      2: v = 31'($urandom_range('h800, 'hFFFF));
      3: v = 31'($urandom_range('h10000, 'h10FFFF));
      4: begin
        case ($urandom_range(0, 15))
          0:  v = 31'h0;
          1:  v = 31'hD7FF;
          2:  v = 31'hD800;
          3:  v = 31'hDFFF;
          4:  v = 31'hE000;
          5:  v = 31'hFDCF;
          6:  v = 31'hFDD0;
          7:  v = 31'hFDEF;
          8:  v = 31'hFDF0;
          9:  v = 31'hFFFD;
          10: v = 31'hFFFE;
          11: v = 31'h1FFFF;
          12: v = 31'h10FFFD;
          13: v = 31'h110000;
          14: v = 31'h7FF;
          default: v = 31'h7FFFFFFF;
        endcase
      end
      5: v = 31'($urandom_range('h110000, 'h3FFFFFF));
      6: v = 31'($urandom);
      default: v = 31'($urandom_range(0, 'hFFFF));
    endcase
    return v;
  endfunction

  // Mostly well-formed sequences with random content; some cut short,
  // some ended by the final flag, some plain noise.
  task fill_random_stream();
    logic [30:0] cp;
    logic [30:0] sh;
    logic [7:0]  b;
    logic        fin_last;
    int len;
    int cut;
    int shape;
    int i;
    while (byte_q.size() < RandomBytes + 30) begin
      shape = $urandom_range(0, 15);
      if (shape < 2) begin
        add_byte(8'($urandom), $urandom_range(0, 15) == 0);
      end else begin
        cp  = pick_code_point();
        len = cp < 31'h80 ? 1 : cp < 31'h800 ? 2 : cp < 31'h10000 ? 3 :
              cp < 31'h200000 ? 4 : cp < 31'h4000000 ? 5 : 6;
        if (len < 6 && $urandom_range(0, 7) == 0) len++;
        cut      = len;
        fin_last = ($urandom_range(0, 19) == 0);
        if (shape == 2 && len > 1) cut = $urandom_range(1, len - 1);
        if (shape == 3 && len > 1) begin
          cut      = $urandom_range(1, len - 1);
          fin_last = 1'b1;
        end
        for (i = 0; i < cut; i++) begin
          sh = cp >> (6 * (len - 1 - i));
          if (len == 1) b = {1'b0, cp[6:0]};
          else if (i == 0) b = (8'hFF << (8 - len)) | (sh[7:0] & (8'hFF >> (len + 1)));
          else b = {2'b10, sh[5:0]};
          add_byte(b, fin_last && i == cut - 1);
        end
      end
    end
  endtask

  // Scoreboard: check results, then predict what each accepted byte causes.
  always @(posedge clk_i) begin
    byte_beat_t taken;
    if (rst_ni) begin
      if (pop && !empty) check_result();
      if (push && !full) begin
        taken = byte_q.pop_front();
        decode_byte(taken.data, taken.fin);
        bytes_sent++;
      end
    end
  end

  // Sender: bursts of beats with random gaps.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else if (burst_left > 0 && byte_q.size() > 0) begin
      push       <= 1'b1;
      data_byte  <= byte_q[0].data;
      final_byte <= byte_q[0].fin;
      burst_left--;
    end else begin
      push       <= 1'b0;
      data_byte  <= 8'($urandom);
      final_byte <= 1'($urandom);
      if (gap_left > 0) begin
        gap_left--;
      end else begin
        burst_left = $urandom_range(1, 48);
        gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
      end
    end
  end

  // Receiver: runs of pops, sometimes thinned, separated by stalls.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold--;
    end else if (pop_go > 0) begin
      pop <= pop_sparse ? 1'($urandom_range(0, 1)) : 1'b1;
      pop_go--;
    end else begin
      pop        <= 1'b0;
      pop_go     = $urandom_range(1, 60);
      pop_sparse = ($urandom_range(0, 3) == 0);
      pop_hold   = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30)
                                                : $urandom_range(0, 2);
    end
  end

  initial begin
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    push             = 1'b0;
    pop              = 1'b0;
    data_byte        = '0;
    final_byte       = 1'b0;
    mismatches       = 0;
    results_seen     = 0;
    valid_seen       = 0;
    term_seen        = 0;
    two_result_bytes = 0;
    bytes_sent       = 0;
    burst_left       = 0;
    gap_left         = 0;
    pop_go           = 0;
    pop_hold         = 0;
    pop_sparse       = 1'b0;
    close_sequence();

    // terminator, ASCII, stray and impossible bytes
    add_byte(8'h00, 1'b0);
    add_byte(8'h7F, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hFE, 1'b0);
    // C0 80 zero, overlong C1 BF
    add_byte(8'hC0, 1'b0); add_byte(8'h80, 1'b0);
    add_byte(8'hC1, 1'b0); add_byte(8'hBF, 1'b0);
    // surrogate, noncharacter U+FFFF, beyond U+10FFFF
    add_byte(8'hED, 1'b0); add_byte(8'hA0, 1'b0); add_byte(8'h80, 1'b0);
    add_byte(8'hEF, 1'b0); add_byte(8'hBF, 1'b0); add_byte(8'hBF, 1'b0);
    add_byte(8'hF4, 1'b0); add_byte(8'h90, 1'b0); add_byte(8'h80, 1'b0);
    add_byte(8'h80, 1'b0);
    // sequence broken by ASCII: two results from one byte
    add_byte(8'hC2, 1'b0); add_byte(8'h41, 1'b0);
    // lead marked final, then final inside an open sequence
    add_byte(8'hDF, 1'b1);
    add_byte(8'hE2, 1'b0); add_byte(8'h82, 1'b1);
    // six-byte form with every payload bit set
    add_byte(8'hFD, 1'b0);
    repeat (5) add_byte(8'hBF, 1'b0);

    fill_random_stream();

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (byte_q.size() != 0) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("Fed %0d bytes; checked %0d results (%0d valid, %0d terminators).",
             bytes_sent, results_seen, valid_seen, term_seen);
    $display("%0d bytes closed one sequence and opened another result.",
             two_result_bytes);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
